/* rtl/plq_pkg.sv */
// shared types and codes for the pooled linked queues block
package plq_pkg;

  localparam int ID_W     = 16;
  localparam int KIND_W   = 2;
  localparam int QSEL_W   = 2;
  localparam int STATUS_W = 2;

  // request kinds
  localparam logic [KIND_W-1:0] REQ_ENQ = 2'd0;
  localparam logic [KIND_W-1:0] REQ_DEQ = 2'd1;
  localparam logic [KIND_W-1:0] REQ_REM = 2'd2;
  localparam logic [KIND_W-1:0] REQ_BAD = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // pool memory port controls
  typedef struct packed {
    logic rd;
    logic link_we;
    logic id_we;
  } mem_ctl_t;

endpackage

/* rtl/plq_pool.sv */
// entry pool memories: id and next link, with a fill mark for the untouched free chain
module plq_pool import plq_pkg::*; #(
  parameter int POOL_ENTRIES = 1024,
  parameter int IW = $clog2(POOL_ENTRIES),
  parameter int LW = $clog2(POOL_ENTRIES + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  mem_ctl_t        ctl,
  input  logic [IW-1:0]   rd_addr,
  input  logic [IW-1:0]   link_wa,
  input  logic [LW-1:0]   link_wd,
  input  logic [IW-1:0]   id_wa,
  input  logic [ID_W-1:0] id_wd,
  output logic [LW-1:0]   link_rd,
  output logic [ID_W-1:0] id_rd
);

  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_ENTRIES);

  logic [LW-1:0]   link_mem [POOL_ENTRIES];
  logic [ID_W-1:0] id_mem   [POOL_ENTRIES];

  // entries below mark were never written and still hold their reset link
  logic [LW-1:0]   mark;
  logic [LW-1:0]   mem_q;
  logic [LW-1:0]   init_q;
  logic            init_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= NULL_LINK;
    end else if (ctl.link_we && (LW'(link_wa) < mark)) begin
      mark <= LW'(link_wa);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (ctl.id_we) begin
      id_mem[id_wa] <= id_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      mem_q    <= link_mem[rd_addr];
      id_rd    <= id_mem[rd_addr];
      init_sel <= (LW'(rd_addr) < mark);
      init_q   <= (rd_addr == '0) ? NULL_LINK : LW'(rd_addr) - LW'(1);
    end
  end

  assign link_rd = init_sel ? init_q : mem_q;

endmodule

/* rtl/plq_seq.sv */
// request sequencer: queue head and tail tables, free list top, list walk
module plq_seq import plq_pkg::*; #(
  parameter int POOL_ENTRIES = 1024,
  parameter int NUM_QUEUES = 4,
  parameter int IW = $clog2(POOL_ENTRIES),
  parameter int LW = $clog2(POOL_ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [KIND_W-1:0]   kind_in,
  input  logic [QSEL_W-1:0]   qsel_in,
  input  logic [ID_W-1:0]     pid_in,
  input  logic                res_free,
  output logic                ready,
  output logic                done,
  output logic [STATUS_W-1:0] res_status,
  output logic [ID_W-1:0]     res_id,
  output mem_ctl_t            ctl,
  output logic [IW-1:0]       rd_addr,
  output logic [IW-1:0]       link_wa,
  output logic [LW-1:0]       link_wd,
  output logic [IW-1:0]       id_wa,
  output logic [ID_W-1:0]     id_wd,
  input  logic [LW-1:0]       link_rd,
  input  logic [ID_W-1:0]     id_rd
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_ENTRIES);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISP     = 3'd1;
  localparam logic [2:0] S_ENQ_WR   = 3'd2;
  localparam logic [2:0] S_ENQ_LINK = 3'd3;
  localparam logic [2:0] S_HEAD     = 3'd4;
  localparam logic [2:0] S_WALK     = 3'd5;
  localparam logic [2:0] S_REL      = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]          state, state_next;
  logic [KIND_W-1:0]   kind;
  logic [QSEL_W-1:0]   qsel;
  logic [ID_W-1:0]     pid;
  logic [LW-1:0]       free_top, free_top_next;
  logic [LW-1:0]       alloc, alloc_next;
  logic [LW-1:0]       prev, prev_next;
  logic [LW-1:0]       cur, cur_next;
  logic [STATUS_W-1:0] res_status_next;
  logic [ID_W-1:0]     res_id_next;
  logic [LW-1:0]       head_tab [NUM_QUEUES];
  logic [LW-1:0]       tail_tab [NUM_QUEUES];

  logic                head_we, tail_we;
  logic [LW-1:0]       head_wd, tail_wd;
  logic [QW-1:0]       q_idx;
  logic                q_bad;
  logic [LW-1:0]       hq, tq;
  logic                id_hit;

  assign q_idx  = QW'(qsel);
  assign q_bad  = (32'(qsel) >= NUM_QUEUES);
  assign hq     = head_tab[q_idx];
  assign tq     = tail_tab[q_idx];
  // the shared compare unit
  assign id_hit = (id_rd == pid);

  assign ready = (state == S_IDLE) || ((state == S_DONE) && res_free);
  assign done  = (state == S_DONE) && res_free;

  always_comb begin
    state_next      = state;
    free_top_next   = free_top;
    alloc_next      = alloc;
    prev_next       = prev;
    cur_next        = cur;
    res_status_next = res_status;
    res_id_next     = res_id;
    head_we         = 1'b0;
    head_wd         = NULL_LINK;
    tail_we         = 1'b0;
    tail_wd         = NULL_LINK;
    ctl             = '0;
    rd_addr         = '0;
    link_wa         = '0;
    link_wd         = NULL_LINK;
    id_wa           = '0;
    id_wd           = pid;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (q_bad || (kind == REQ_BAD)) begin
          res_status_next = ST_MISS;
          res_id_next     = '0;
          state_next      = S_DONE;
        end else if (kind == REQ_ENQ) begin
          if (free_top >= NULL_LINK) begin
            res_status_next = ST_FULL;
            res_id_next     = '0;
            state_next      = S_DONE;
          end else begin
            ctl.rd     = 1'b1;
            rd_addr    = IW'(free_top);
            alloc_next = free_top;
            prev_next  = tq;
            state_next = S_ENQ_WR;
          end
        end else if (hq >= NULL_LINK) begin
          res_status_next = ST_MISS;
          res_id_next     = '0;
          state_next      = S_DONE;
        end else begin
          ctl.rd     = 1'b1;
          rd_addr    = IW'(hq);
          prev_next  = hq;
          state_next = S_HEAD;
        end
      end
      S_ENQ_WR: begin
        free_top_next   = link_rd;
        ctl.link_we     = 1'b1;
        link_wa         = IW'(alloc);
        link_wd         = NULL_LINK;
        ctl.id_we       = 1'b1;
        id_wa           = IW'(alloc);
        id_wd           = pid;
        tail_we         = 1'b1;
        tail_wd         = alloc;
        res_status_next = ST_OK;
        res_id_next     = pid;
        if ((hq >= NULL_LINK) || (tq >= NULL_LINK)) begin
          head_we    = 1'b1;
          head_wd    = alloc;
          state_next = S_DONE;
        end else begin
          state_next = S_ENQ_LINK;
        end
      end
      S_ENQ_LINK: begin
        // old tail now points at the new entry
        ctl.link_we = 1'b1;
        link_wa     = IW'(prev);
        link_wd     = alloc;
        state_next  = S_DONE;
      end
      S_HEAD: begin
        if ((kind == REQ_DEQ) || id_hit) begin
          head_we = 1'b1;
          head_wd = link_rd;
          if (link_rd >= NULL_LINK) begin
            tail_we = 1'b1;
            tail_wd = NULL_LINK;
          end
          ctl.link_we     = 1'b1;
          link_wa         = IW'(prev);
          link_wd         = free_top;
          free_top_next   = prev;
          res_status_next = ST_OK;
          res_id_next     = id_rd;
          state_next      = S_DONE;
        end else if (link_rd >= NULL_LINK) begin
          res_status_next = ST_MISS;
          res_id_next     = '0;
          state_next      = S_DONE;
        end else begin
          ctl.rd     = 1'b1;
          rd_addr    = IW'(link_rd);
          cur_next   = link_rd;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (id_hit) begin
          // splice cur out, predecessor takes its link
          ctl.link_we = 1'b1;
          link_wa     = IW'(prev);
          link_wd     = link_rd;
          if (tq == cur) begin
            tail_we = 1'b1;
            tail_wd = prev;
          end
          res_status_next = ST_OK;
          res_id_next     = pid;
          state_next      = S_REL;
        end else if (link_rd >= NULL_LINK) begin
          res_status_next = ST_MISS;
          res_id_next     = '0;
          state_next      = S_DONE;
        end else begin
          ctl.rd    = 1'b1;
          rd_addr   = IW'(link_rd);
          prev_next = cur;
          cur_next  = link_rd;
        end
      end
      S_REL: begin
        ctl.link_we   = 1'b1;
        link_wa       = IW'(cur);
        link_wd       = free_top;
        free_top_next = cur;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (res_free) begin
          state_next = start ? S_DISP : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      free_top <= LW'(POOL_ENTRIES - 1);
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_tab[i] <= NULL_LINK;
        tail_tab[i] <= NULL_LINK;
      end
    end else begin
      state    <= state_next;
      free_top <= free_top_next;
      if (head_we) begin
        head_tab[q_idx] <= head_wd;
      end
      if (tail_we) begin
        tail_tab[q_idx] <= tail_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      kind <= kind_in;
      qsel <= qsel_in;
      pid  <= pid_in;
    end
    alloc      <= alloc_next;
    prev       <= prev_next;
    cur        <= cur_next;
    res_status <= res_status_next;
    res_id     <= res_id_next;
  end

endmodule

/* rtl/pooled_linked_queues_core.sv */
// top level of the pooled linked queues block: stream ports and result register
// an enqueue into a nonempty queue also links the old tail to the new entry; a
// dequeue or a remove that matches at the head unlinks it there, while a remove
// further down walks the list, then splices out and releases the match; refusals
// at dispatch go straight to the result; the next word is taken in the cycle the
// result moves into the output register; one pool read per cycle sets the pace
// reset clears the head and tail tables and sets the free list top to the last entry; the free chain is
// formed lazily by a fill mark, so no clearing pass is needed after reset
module pooled_linked_queues_core import plq_pkg::*; #(
  parameter int POOL_ENTRIES = 1024,
  parameter int NUM_QUEUES = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [ID_W-1:0]            s_tdata,   // proc_id
  input  logic [KIND_W+QSEL_W-1:0]   s_tuser,   // req_type, queue_sel
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [ID_W-1:0]            m_tdata,   // id_out
  output logic [STATUS_W-1:0]        m_tuser    // status
);

  localparam int IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int LW = $clog2(POOL_ENTRIES + 1);

  mem_ctl_t            ctl;
  logic [IW-1:0]       rd_addr, link_wa, id_wa;
  logic [LW-1:0]       link_wd, link_rd;
  logic [ID_W-1:0]     id_wd, id_rd;
  logic                seq_ready, seq_done, start, res_free;
  logic [STATUS_W-1:0] res_status;
  logic [ID_W-1:0]     res_id;

  // result slot is free when empty or being drained this cycle
  assign res_free = !m_tvalid || m_tready;
  assign s_tready = seq_ready;
  assign start    = s_tvalid && seq_ready;

  plq_seq #(
    .POOL_ENTRIES(POOL_ENTRIES),
    .NUM_QUEUES(NUM_QUEUES),
    .IW(IW),
    .LW(LW)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .start(start),
    .kind_in(s_tuser[KIND_W-1:0]),
    .qsel_in(s_tuser[KIND_W+QSEL_W-1:KIND_W]),
    .pid_in(s_tdata),
    .res_free(res_free),
    .ready(seq_ready),
    .done(seq_done),
    .res_status(res_status),
    .res_id(res_id),
    .ctl(ctl),
    .rd_addr(rd_addr),
    .link_wa(link_wa),
    .link_wd(link_wd),
    .id_wa(id_wa),
    .id_wd(id_wd),
    .link_rd(link_rd),
    .id_rd(id_rd)
  );

  plq_pool #(
    .POOL_ENTRIES(POOL_ENTRIES),
    .IW(IW),
    .LW(LW)
  ) u_pool (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .rd_addr(rd_addr),
    .link_wa(link_wa),
    .link_wd(link_wd),
    .id_wa(id_wa),
    .id_wd(id_wd),
    .link_rd(link_rd),
    .id_rd(id_rd)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (seq_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done) begin
      m_tdata <= res_id;
      m_tuser <= res_status;
    end
  end

  // a finished result never lands on a word still waiting at the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    seq_done |-> res_free)
    else $error("result written over a pending output word");

  // an accepted request keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while previous one in progress");

  // failed requests always carry a zero id
  a_fail_zero_id: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0))
    else $error("nonzero id on failed request");

endmodule
